@@ rtl/assert_macros.svh @@
// Assertion macros for the contact force RTL.
// No dependencies; assertions vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/cff_pkg.sv @@
// Package for the contact force core: Q16.16 helpers and register codes.
// No dependencies.
`default_nettype none
package cff_pkg;
    localparam int unsigned QW = 32;
    localparam int unsigned RW = 31;
    localparam int unsigned LATENCY = 7;

    localparam logic [2:0] REG_KN = 3'd0;
    localparam logic [2:0] REG_KS = 3'd1;
    localparam logic [2:0] REG_GN = 3'd2;
    localparam logic [2:0] REG_MU = 3'd3;
    localparam logic [2:0] REG_DT = 3'd4;

    localparam logic [RW-1:0] KN_RESET = 31'd65536000;
    localparam logic [RW-1:0] KS_RESET = 31'd49152000;
    localparam logic [RW-1:0] GN_RESET = 31'd0;
    localparam logic [RW-1:0] MU_RESET = 31'd32768;
    localparam logic [RW-1:0] DT_RESET = 31'd66;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7fffffff;
        if (v < -34'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // round a 65-bit signed product to Q16.16 (half up) and saturate
    function automatic logic signed [31:0] qround(input logic signed [64:0] p);
        logic signed [64:0] s;
        logic signed [48:0] q;
        s = p + 65'sd32768;
        q = s[64:16];
        if (q > 49'sd2147483647) return 32'sh7fffffff;
        if (q < -49'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    function automatic logic signed [32:0] sx(input logic signed [31:0] a);
        return {a[31], a};
    endfunction

    function automatic logic signed [32:0] ux(input logic [RW-1:0] a);
        return {2'b00, a};
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return sat34({{2{a[31]}}, a} + {{2{b[31]}}, b});
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        return sat34({{2{a[31]}}, a} - {{2{b[31]}}, b});
    endfunction

    function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
        return sat34(34'sd0 - {{2{a[31]}}, a});
    endfunction

    typedef struct packed {
        logic [RW-1:0] kn;
        logic [RW-1:0] ks;
        logic [RW-1:0] gn;
        logic [RW-1:0] mu;
        logic [RW-1:0] dt;
    } t_cfg;
endpackage
`default_nettype wire

@@ rtl/cff_qmul.sv @@
// One registered Q16.16 multiply with round-half-up and saturation.
// Depends on cff_pkg.
`default_nettype none
module cff_qmul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [31:0]      o_p
);
    logic signed [64:0] n_p;
    logic signed [31:0] r_p;
    assign n_p = 65'(i_a) * 65'(i_b);
    always_ff @(posedge i_clk) begin
        r_p <= cff_pkg::qround(n_p);
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

@@ rtl/cff_regs.sv @@
// Configuration register file for the contact force core.
// Depends on cff_pkg.
`default_nettype none
module cff_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output cff_pkg::t_cfg    o_cfg
);
    cff_pkg::t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kn <= cff_pkg::KN_RESET;
            r_cfg.ks <= cff_pkg::KS_RESET;
            r_cfg.gn <= cff_pkg::GN_RESET;
            r_cfg.mu <= cff_pkg::MU_RESET;
            r_cfg.dt <= cff_pkg::DT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cff_pkg::REG_KN: r_cfg.kn <= i_cfg_data[30:0];
                cff_pkg::REG_KS: r_cfg.ks <= i_cfg_data[30:0];
                cff_pkg::REG_GN: r_cfg.gn <= i_cfg_data[30:0];
                cff_pkg::REG_MU: r_cfg.mu <= i_cfg_data[30:0];
                cff_pkg::REG_DT: r_cfg.dt <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end
    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

@@ rtl/contact_force_with_friction_core.sv @@
// Top level of the 2D spring-dashpot contact force core with Coulomb friction.
// Depends on cff_pkg, cff_regs, cff_qmul and assert_macros.svh.
//
//  channel | handshake                | beat
//  --------+--------------------------+-------------------------------
//  input   | i_start & !o_busy        | gap, normal, velocities, radii
//  config  | i_cfg_valid & o_cfg_ready| register index and data
//  result  | o_done (one cycle)       | forces, torques, slipped
//
// The pipeline from accept to o_done is set by four dependent multiplies
// (first products, ks*vt, then *dt, then the force projection), with the input
// register, the product sums and the output register around them.
// One contact enters every cycle; o_busy stays low, nothing stalls.
// Reset is synchronous, active low, clears the valid bits and loads the config reset values.
`default_nettype none
`include "assert_macros.svh"
module contact_force_with_friction_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic signed [31:0] i_gap,
    input  wire logic signed [31:0] i_normal_x,
    input  wire logic signed [31:0] i_normal_y,
    input  wire logic signed [31:0] i_vel_i_x,
    input  wire logic signed [31:0] i_vel_i_y,
    input  wire logic signed [31:0] i_vel_j_x,
    input  wire logic signed [31:0] i_vel_j_y,
    input  wire logic signed [31:0] i_spin_i,
    input  wire logic [30:0]        i_radius_i,
    input  wire logic signed [31:0] i_spin_j,
    input  wire logic [30:0]        i_radius_j,
    input  wire logic signed [31:0] i_prev_tangential,
    output logic             o_done,
    output logic signed [31:0] o_normal_force,
    output logic signed [31:0] o_tangential_force,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic signed [31:0] o_torque_i,
    output logic signed [31:0] o_torque_j,
    output logic             o_slipped
);
    cff_pkg::t_cfg cfg;
    logic accept;
    logic [cff_pkg::LATENCY-1:0] r_vld;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start & ~o_busy;

    cff_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid & o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    // valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[cff_pkg::LATENCY-2:0], accept};
    end

    // stage 1: differences, tangent, register inputs
    logic signed [31:0] r1_gap, r1_nx, r1_ny, r1_tx, r1_dvx, r1_dvy, r1_wi, r1_wj, r1_prev;
    logic [30:0] r1_ri, r1_rj;
    always_ff @(posedge i_clk) begin
        r1_gap  <= i_gap;
        r1_nx   <= i_normal_x;
        r1_ny   <= i_normal_y;
        r1_tx   <= cff_pkg::qneg(i_normal_y);
        r1_dvx  <= cff_pkg::qsub(i_vel_j_x, i_vel_i_x);
        r1_dvy  <= cff_pkg::qsub(i_vel_j_y, i_vel_i_y);
        r1_wi   <= i_spin_i;
        r1_wj   <= i_spin_j;
        r1_ri   <= i_radius_i;
        r1_rj   <= i_radius_j;
        r1_prev <= i_prev_tangential;
    end

    // stage 2: first products
    logic signed [31:0] p_ndx, p_ndy, p_tdx, p_tdy, p_wr_i, p_wr_j, p_gk;
    cff_qmul u_m1 (.i_clk(i_clk), .i_a(cff_pkg::sx(r1_nx)), .i_b(cff_pkg::sx(r1_dvx)), .o_p(p_ndx));
    cff_qmul u_m2 (.i_clk(i_clk), .i_a(cff_pkg::sx(r1_ny)), .i_b(cff_pkg::sx(r1_dvy)), .o_p(p_ndy));
    cff_qmul u_m3 (.i_clk(i_clk), .i_a(cff_pkg::sx(r1_tx)), .i_b(cff_pkg::sx(r1_dvx)), .o_p(p_tdx));
    cff_qmul u_m4 (.i_clk(i_clk), .i_a(cff_pkg::sx(r1_nx)), .i_b(cff_pkg::sx(r1_dvy)), .o_p(p_tdy));
    cff_qmul u_m5 (.i_clk(i_clk), .i_a(cff_pkg::sx(r1_wi)), .i_b(cff_pkg::ux(r1_ri)), .o_p(p_wr_i));
    cff_qmul u_m6 (.i_clk(i_clk), .i_a(cff_pkg::sx(r1_wj)), .i_b(cff_pkg::ux(r1_rj)), .o_p(p_wr_j));
    cff_qmul u_m7 (.i_clk(i_clk), .i_a(cff_pkg::sx(r1_gap)), .i_b(cff_pkg::ux(cfg.kn)), .o_p(p_gk));
    logic signed [31:0] r2_nx, r2_ny, r2_tx, r2_prev;
    logic [30:0] r2_ri, r2_rj;
    always_ff @(posedge i_clk) begin
        r2_nx <= r1_nx; r2_ny <= r1_ny; r2_tx <= r1_tx; r2_prev <= r1_prev;
        r2_ri <= r1_ri; r2_rj <= r1_rj;
    end

    // stage 3: sums of first products
    logic signed [31:0] r3_vn, r3_vt, r3_fel, r3_nx, r3_ny, r3_tx, r3_prev;
    logic [30:0] r3_ri, r3_rj;
    always_ff @(posedge i_clk) begin
        r3_vn   <= cff_pkg::qadd(p_ndx, p_ndy);
        r3_vt   <= cff_pkg::qsub(cff_pkg::qsub(cff_pkg::qadd(p_tdx, p_tdy), p_wr_i), p_wr_j);
        r3_fel  <= cff_pkg::qneg(p_gk);
        r3_nx <= r2_nx; r3_ny <= r2_ny; r3_tx <= r2_tx; r3_prev <= r2_prev;
        r3_ri <= r2_ri; r3_rj <= r2_rj;
    end

    // stage 4: damping, ks*vt, friction limit
    logic signed [31:0] p_vg, p_kv, p_lim;
    cff_qmul u_m8 (.i_clk(i_clk), .i_a(cff_pkg::sx(r3_vn)), .i_b(cff_pkg::ux(cfg.gn)), .o_p(p_vg));
    cff_qmul u_m9 (.i_clk(i_clk), .i_a(cff_pkg::ux(cfg.ks)), .i_b(cff_pkg::sx(r3_vt)), .o_p(p_kv));
    cff_qmul u_m10 (.i_clk(i_clk), .i_a(cff_pkg::ux(cfg.mu)), .i_b(cff_pkg::sx(r3_fel)), .o_p(p_lim));
    logic signed [31:0] r4_fel, r4_nx, r4_ny, r4_tx, r4_prev;
    logic [30:0] r4_ri, r4_rj;
    always_ff @(posedge i_clk) begin
        r4_fel <= r3_fel; r4_nx <= r3_nx; r4_ny <= r3_ny; r4_tx <= r3_tx;
        r4_prev <= r3_prev; r4_ri <= r3_ri; r4_rj <= r3_rj;
    end

    // stage 5: normal force, times dt
    logic signed [31:0] p_kvdt;
    cff_qmul u_m11 (.i_clk(i_clk), .i_a(cff_pkg::sx(p_kv)), .i_b(cff_pkg::ux(cfg.dt)), .o_p(p_kvdt));
    logic signed [31:0] r5_fn, r5_lim, r5_nx, r5_ny, r5_tx, r5_prev;
    logic [30:0] r5_ri, r5_rj;
    always_ff @(posedge i_clk) begin
        r5_fn  <= cff_pkg::qadd(r4_fel, cff_pkg::qneg(p_vg));
        r5_lim <= p_lim;
        r5_nx <= r4_nx; r5_ny <= r4_ny; r5_tx <= r4_tx; r5_prev <= r4_prev;
        r5_ri <= r4_ri; r5_rj <= r4_rj;
    end

    // stage 5 comb: tangential update and Coulomb clamp
    // The magnitude keeps 33 bits so the most negative force still exceeds any limit.
    logic signed [31:0] ft_raw, ft_cl;
    logic signed [32:0] ft_mag;
    logic               slip;
    always_comb begin
        ft_raw = cff_pkg::qsub(r5_prev, p_kvdt);
        ft_mag = ft_raw[31] ? (33'sd0 - cff_pkg::sx(ft_raw)) : cff_pkg::sx(ft_raw);
        slip   = ft_mag > cff_pkg::sx(r5_lim);
        if (!slip)                  ft_cl = ft_raw;
        else if (ft_raw > 32'sd0)   ft_cl = r5_lim;
        else                        ft_cl = cff_pkg::qneg(r5_lim);
    end

    // stage 6: output projection products
    logic signed [31:0] p_fnx, p_fny, p_ftx, p_fty, p_fri, p_frj;
    cff_qmul u_m12 (.i_clk(i_clk), .i_a(cff_pkg::sx(r5_fn)), .i_b(cff_pkg::sx(r5_nx)), .o_p(p_fnx));
    cff_qmul u_m13 (.i_clk(i_clk), .i_a(cff_pkg::sx(r5_fn)), .i_b(cff_pkg::sx(r5_ny)), .o_p(p_fny));
    cff_qmul u_m14 (.i_clk(i_clk), .i_a(cff_pkg::sx(ft_cl)), .i_b(cff_pkg::sx(r5_tx)), .o_p(p_ftx));
    cff_qmul u_m15 (.i_clk(i_clk), .i_a(cff_pkg::sx(ft_cl)), .i_b(cff_pkg::sx(r5_nx)), .o_p(p_fty));
    cff_qmul u_m16 (.i_clk(i_clk), .i_a(cff_pkg::sx(ft_cl)), .i_b(cff_pkg::ux(r5_ri)), .o_p(p_fri));
    cff_qmul u_m17 (.i_clk(i_clk), .i_a(cff_pkg::sx(ft_cl)), .i_b(cff_pkg::ux(r5_rj)), .o_p(p_frj));
    logic signed [31:0] r6_fn, r6_ft;
    logic               r6_slip;
    always_ff @(posedge i_clk) begin
        r6_fn <= r5_fn; r6_ft <= ft_cl; r6_slip <= slip;
    end

    // stage 7: output register
    logic signed [31:0] r_fn, r_ft, r_fx, r_fy, r_ti, r_tj;
    logic               r_slip;
    always_ff @(posedge i_clk) begin
        r_fn   <= r6_fn;
        r_ft   <= r6_ft;
        r_fx   <= cff_pkg::qadd(p_fnx, p_ftx);
        r_fy   <= cff_pkg::qadd(p_fny, p_fty);
        r_ti   <= cff_pkg::qneg(p_fri);
        r_tj   <= cff_pkg::qneg(p_frj);
        r_slip <= r6_slip;
    end

    assign o_done             = r_vld[cff_pkg::LATENCY-1];
    assign o_normal_force     = r_fn;
    assign o_tangential_force = r_ft;
    assign o_force_x          = r_fx;
    assign o_force_y          = r_fy;
    assign o_torque_i         = r_ti;
    assign o_torque_j         = r_tj;
    assign o_slipped          = r_slip;

    `ASSERT_NEXT(a_start_done, i_clk, i_rst_n, accept, r_vld[0])
    `ASSERT_IMPLIES(a_done_chain, i_clk, i_rst_n, o_done, $past(r_vld[cff_pkg::LATENCY-2]))
    `ASSERT_IMPLIES(a_noslip_kept, i_clk, i_rst_n, r_vld[4] && !slip, ft_cl == ft_raw)
endmodule
`default_nettype wire

@@ bench/contact_force_with_friction_core_test.sv @@
// Self-checking bench for contact_force_with_friction_core: directed contacts, then random ones.
// Depends on cff_pkg for register codes and latency; predicts results in Q16.16 itself.
`timescale 1ns / 100ps
`default_nettype none
module contact_force_with_friction_core_test;

    typedef struct {
        logic signed [31:0] gap, nx, ny, vix, viy, vjx, vjy, wi;
        logic [30:0]        ri;
        logic signed [31:0] wj;
        logic [30:0]        rj;
        logic signed [31:0] prev;
    } t_contact;

    typedef struct {
        logic signed [31:0] fn, ft, fx, fy, gi, gj;
        logic               slip;
    } t_force;

    typedef struct {
        t_contact c;
        bit       typed;   // expected result typed in below
        t_force   f;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic signed [31:0] i_gap = '0, i_normal_x = '0, i_normal_y = '0;
    logic signed [31:0] i_vel_i_x = '0, i_vel_i_y = '0, i_vel_j_x = '0, i_vel_j_y = '0;
    logic signed [31:0] i_spin_i = '0, i_spin_j = '0, i_prev_tangential = '0;
    logic [30:0] i_radius_i = '0, i_radius_j = '0;
    logic        o_busy, o_cfg_ready, o_done, o_slipped;
    logic signed [31:0] o_normal_force, o_tangential_force, o_force_x, o_force_y;
    logic signed [31:0] o_torque_i, o_torque_j;

    contact_force_with_friction_core u_dut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .i_gap, .i_normal_x, .i_normal_y,
        .i_vel_i_x, .i_vel_i_y, .i_vel_j_x, .i_vel_j_y, .i_spin_i, .i_radius_i,
        .i_spin_j, .i_radius_j, .i_prev_tangential, .o_done, .o_normal_force,
        .o_tangential_force, .o_force_x, .o_force_y, .o_torque_i, .o_torque_j,
        .o_slipped
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the coefficient registers, indexed by register code.
    longint coef [5];
    t_force pending_forces [$];
    int     errors = 0;
    bit     idling = 1'b1;

    // Saturate to the signed 32-bit range.
    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, rounded half up, then saturated.
    function automatic longint fxmul(longint a, longint b);
        return clamp32((a * b + 32768) >>> 16);
    endfunction

    function automatic t_force predict_contact(t_contact c);
        longint dvx, dvy, tx, ty, vn, fel, fn, vt, ft, lim, mag;
        t_force f;
        dvx = clamp32(longint'(c.vjx) - longint'(c.vix));
        dvy = clamp32(longint'(c.vjy) - longint'(c.viy));
        tx  = clamp32(-longint'(c.ny));
        ty  = longint'(c.nx);
        vn  = clamp32(fxmul(c.nx, dvx) + fxmul(c.ny, dvy));
        fel = clamp32(-fxmul(c.gap, coef[cff_pkg::REG_KN]));
        fn  = clamp32(fel + clamp32(-fxmul(vn, coef[cff_pkg::REG_GN])));
        vt  = clamp32(fxmul(tx, dvx) + fxmul(ty, dvy));
        vt  = clamp32(vt - fxmul(c.wi, longint'({1'b0, c.ri})));
        vt  = clamp32(vt - fxmul(c.wj, longint'({1'b0, c.rj})));
        ft  = clamp32(longint'(c.prev)
                      - fxmul(fxmul(coef[cff_pkg::REG_KS], vt), coef[cff_pkg::REG_DT]));
        lim = fxmul(coef[cff_pkg::REG_MU], fel);
        mag = (ft < 0) ? -ft : ft;
        f.slip = (mag > lim);
        // A zero force over the limit takes the negative branch.
        if (f.slip) ft = (ft > 0) ? lim : clamp32(-lim);
        f.fn = fn[31:0];
        f.ft = ft[31:0];
        f.fx = 32'(clamp32(fxmul(fn, c.nx) + fxmul(ft, tx)));
        f.fy = 32'(clamp32(fxmul(fn, c.ny) + fxmul(ft, ty)));
        f.gi = 32'(clamp32(-fxmul(ft, longint'({1'b0, c.ri}))));
        f.gj = 32'(clamp32(-fxmul(ft, longint'({1'b0, c.rj}))));
        return f;
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
        errors++;
    endtask

    // Check each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_force w;
        if (i_rst_n && o_done) begin
            if (pending_forces.size() == 0) begin
                report("unexpected beat", '0, '0);
            end else begin
                w = pending_forces.pop_front();
                if (o_normal_force !== w.fn) report("normal_force", w.fn, o_normal_force);
                if (o_tangential_force !== w.ft)
                    report("tangential_force", w.ft, o_tangential_force);
                if (o_force_x !== w.fx) report("force_x", w.fx, o_force_x);
                if (o_force_y !== w.fy) report("force_y", w.fy, o_force_y);
                if (o_torque_i !== w.gi) report("torque_i", w.gi, o_torque_i);
                if (o_torque_j !== w.gj) report("torque_j", w.gj, o_torque_j);
                if (o_slipped !== w.slip) report("slipped", w.slip, o_slipped);
            end
        end
    end

    // Drive one contact; hold it until the core takes the beat.
    task automatic send_contact(t_contact c, bit typed, t_force f);
        while (idling && $urandom_range(99) < 24) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_gap <= c.gap; i_normal_x <= c.nx; i_normal_y <= c.ny;
        i_vel_i_x <= c.vix; i_vel_i_y <= c.viy; i_vel_j_x <= c.vjx; i_vel_j_y <= c.vjy;
        i_spin_i <= c.wi; i_radius_i <= c.ri; i_spin_j <= c.wj; i_radius_j <= c.rj;
        i_prev_tangential <= c.prev;
        do @(posedge i_clk); while (o_busy);
        pending_forces.push_back(typed ? f : predict_contact(c));
    endtask

    // Write a register once all results are out and the pipe has drained.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_start <= 1'b0;
        wait (pending_forces.size() == 0);
        repeat (cff_pkg::LATENCY + 2) @(posedge i_clk);
        while (idling && $urandom_range(99) < 24) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        // Indexes past the list are dropped; bit 31 of the data is dropped.
        if (idx <= cff_pkg::REG_DT) coef[idx] = longint'(data[30:0]);
    endtask

    function automatic logic [31:0] any_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Signed value of modest Q16.16 magnitude, at most span/65536.
    function automatic logic signed [31:0] modest(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_contact random_contact();
        t_contact c;
        int ang;
        if ($urandom_range(99) < 25) begin
            // noise: every field over its whole range
            c.gap = any_word(); c.nx = any_word(); c.ny = any_word();
            c.vix = any_word(); c.viy = any_word(); c.vjx = any_word();
            c.vjy = any_word(); c.wi = any_word(); c.wj = any_word();
            c.ri = 31'(any_word()); c.rj = 31'(any_word()); c.prev = any_word();
        end else begin
            // plausible contact: small overlap, near-unit normal, slow grains
            ang = $urandom_range(65536);
            c.nx = ($urandom_range(1)) ? ang : -ang;
            c.ny = ($urandom_range(1)) ? 65536 - ang / 2 : ang / 2 - 65536;
            c.gap = ($urandom_range(9) == 0) ? modest(2000) : -$signed($urandom_range(3000));
            c.vix = modest(200000); c.viy = modest(200000);
            c.wi = modest(300000); c.ri = 31'($urandom_range(1000, 40000));
            c.prev = modest(2000000);
            if ($urandom_range(3) == 0) begin
                // wall contact: j motion is zero
                c.vjx = '0; c.vjy = '0; c.wj = '0; c.rj = '0;
            end else begin
                c.vjx = modest(200000); c.vjy = modest(200000);
                c.wj = modest(300000); c.rj = 31'($urandom_range(1000, 40000));
            end
        end
        return c;
    endfunction

    function automatic t_contact make_contact(logic [31:0] gap, nx, ny, vix, viy, vjx,
                                              vjy, wi, ri, wj, rj, prev);
        t_contact c;
        c.gap = gap; c.nx = nx; c.ny = ny; c.vix = vix; c.viy = viy;
        c.vjx = vjx; c.vjy = vjy; c.wi = wi; c.ri = ri[30:0]; c.wj = wj;
        c.rj = rj[30:0]; c.prev = prev;
        return c;
    endfunction

    localparam logic [31:0] MX = 32'h7fff_ffff;
    localparam logic [31:0] MN = 32'h8000_0000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    t_row   plan [$];
    t_row   r;
    t_force nothing;

    initial begin
        nothing = '{default: '0};
        coef[cff_pkg::REG_KN] = cff_pkg::KN_RESET; coef[cff_pkg::REG_KS] = cff_pkg::KS_RESET;
        coef[cff_pkg::REG_GN] = cff_pkg::GN_RESET; coef[cff_pkg::REG_MU] = cff_pkg::MU_RESET;
        coef[cff_pkg::REG_DT] = cff_pkg::DT_RESET;

        // Directed table. Typed rows: all zero gives all zero; a one-unit gap with
        // everything else zero is separated, so it slips with ft = -lim.
        r = '{make_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, nothing};
        plan.push_back(r);
        r = '{make_contact(ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              '{-32'sd65536000, 32'sd32768000, 0, 0, 0, 0, 1'b1}};
        plan.push_back(r);
        r.typed = 0;
        r.c = make_contact(MN, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);          plan.push_back(r);
        r.c = make_contact(MX, 0, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0);          plan.push_back(r);
        r.c = make_contact(-32'sd655, MX, MN, 0, 0, 0, 0, 0, 0, 0, 0, 0);   plan.push_back(r);
        r.c = make_contact(-32'sd655, MN, MX, MX, MN, MN, MX, 0, 0, 0, 0, 0);
        plan.push_back(r);
        r.c = make_contact(-32'sd655, ONE, 0, MN, MX, MX, MN, 0, 0, 0, 0, 0);
        plan.push_back(r);
        r.c = make_contact(-32'sd655, 0, ONE, 0, 0, 0, 0, MX, MX, MN, MX, 0);
        plan.push_back(r);
        r.c = make_contact(-32'sd655, 0, -ONE, 0, 0, 0, 0, MN, MX, MX, MX, 0);
        plan.push_back(r);
        r.c = make_contact(-32'sd655, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, MX); plan.push_back(r);
        r.c = make_contact(-32'sd655, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, MN); plan.push_back(r);
        r.c = make_contact(-32'sd655, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 100); plan.push_back(r);
        r.c = make_contact(MN, MN, MN, MN, MN, MN, MN, MN, MX, MN, MX, MN); plan.push_back(r);
        r.c = make_contact(MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX); plan.push_back(r);
        r.c = make_contact(-1, -1, -1, -1, -1, -1, -1, -1, 1, -1, 1, -1);   plan.push_back(r);
        r.c = make_contact(-32'sd3000, 32'sd46341, 32'sd46341, ONE, 0, -ONE, 0,
                           32'sd20000, 32'sd9000, -32'sd20000, 32'sd9000, 32'sd40000);
        plan.push_back(r);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) send_contact(plan[k].c, plan[k].typed, plan[k].f);

        // Random phases, each under a different register setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;  // keep reset values
                1: begin  // extremes high, with bit 31 set to check it is dropped
                    for (int k = 0; k <= cff_pkg::REG_DT; k++) write_reg(3'(k), 32'hffff_ffff);
                    write_reg(3'd5, 32'h1234_5678);
                end
                2: begin  // all zero
                    for (int k = 0; k <= cff_pkg::REG_DT; k++) write_reg(3'(k), 32'h8000_0000);
                    write_reg(3'd7, MX);
                end
                3: begin  // heavy damping and sticky friction
                    write_reg(cff_pkg::REG_KN, 32'd6553600);
                    write_reg(cff_pkg::REG_KS, 32'd3276800);
                    write_reg(cff_pkg::REG_GN, 32'd655360);
                    write_reg(cff_pkg::REG_MU, 32'd131072);
                    write_reg(cff_pkg::REG_DT, 32'd655);
                    write_reg(3'd6, '0);
                end
                4: for (int k = 0; k <= cff_pkg::REG_DT; k++) write_reg(3'(k), $urandom);
                default: begin  // back to reset values, damping on
                    write_reg(cff_pkg::REG_KN, cff_pkg::KN_RESET);
                    write_reg(cff_pkg::REG_KS, cff_pkg::KS_RESET);
                    write_reg(cff_pkg::REG_GN, 32'd65536);
                    write_reg(cff_pkg::REG_MU, cff_pkg::MU_RESET);
                    write_reg(cff_pkg::REG_DT, cff_pkg::DT_RESET);
                end
            endcase
            for (int n = 0; n < 140; n++) begin
                // one long stretch with both sides busy every cycle
                idling = !(ph == 3);
                send_contact(random_contact(), 1'b0, nothing);
            end
            idling = 1'b1;
        end
        i_start <= 1'b0;

        wait (pending_forces.size() == 0);
        repeat (cff_pkg::LATENCY + 4) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/cff_pkg.sv
rtl/cff_qmul.sv
rtl/cff_regs.sv
rtl/contact_force_with_friction_core.sv
bench/contact_force_with_friction_core_test.sv
